// ===== src/assert_macros.svh =====
// Assertion macros for the list block's RTL, included by the datapath.
// Depends on nothing; each user names its own clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check with a fixed message, held off while reset is active.
`define BLI_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("list block assertion failed");

// Concurrent check with a message of the caller's choosing.
`define BLI_ASSERT_MSG(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

`endif

// ===== src/bli_pkg.sv =====
// Shared types and constants for the bounded list block.
// Used by the controller, the datapath and the top level; depends on nothing.
package bli_pkg;

	// Default list capacity and the fixed widths of the word fields.
	localparam int BLI_CAPACITY = 64;
	localparam int DATA_W       = 64;
	localparam int POS_W        = 6;
	localparam int OP_W         = 2;

	// Operation codes carried by an input word.
	typedef enum logic [OP_W-1:0] {
		OP_INS_FRONT = 2'd0,
		OP_APPEND    = 2'd1,
		OP_DELETE    = 2'd2,
		OP_REPORT    = 2'd3
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic shift;
		logic load;
		logic report;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic del_shift;
		logic left_zero;
		logic left_one;
		logic empty;
	} sts_t;

endpackage

// ===== src/bli_ctrl.sv =====
// Controller state machine for the bounded list block.
// Depends on bli_pkg for the command and status structs.
module bli_ctrl import bli_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SHIFT  = 4'b0010,
		ST_LOAD   = 4'b0100,
		ST_REPORT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next-state logic: accept, close the gap of a delete, set up the scan, scan.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = sts.del_shift ? ST_SHIFT : ST_LOAD;
				end
			end
			ST_SHIFT: begin
				if (sts.left_zero) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = sts.empty ? ST_IDLE : ST_REPORT;
			end
			ST_REPORT: begin
				if (sts.left_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands decoded from the state.
	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && start;
		cmd.shift  = (state_q == ST_SHIFT);
		cmd.load   = (state_q == ST_LOAD);
		cmd.report = (state_q == ST_REPORT);
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== src/bli_dp.sv =====
// Datapath for the bounded list block: circular entry memory, pointers, counters
// and the result register. Depends on bli_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bli_dp import bli_pkg::*; #(
	parameter int CAPACITY = BLI_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [OP_W-1:0]          operation,
	input  logic signed [DATA_W-1:0] value,
	input  logic [POS_W-1:0]         position,
	output logic                     result_valid,
	output logic signed [DATA_W-1:0] element,
	output logic                     is_last,
	output logic                     list_empty,
	output logic                     dropped
);

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam int SW   = ((AW > POS_W) ? AW : POS_W) + 1;
	localparam logic [AW-1:0] LAST_ADDR  = AW'(CAPACITY - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
	localparam logic [SW-1:0] CAP_SUM    = SW'(CAPACITY);

	// Next address round the ring.
	function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
		return (a == LAST_ADDR) ? '0 : a + AW'(1);
	endfunction

	// Previous address round the ring.
	function automatic logic [AW-1:0] addr_dec(input logic [AW-1:0] a);
		return (a == '0) ? LAST_ADDR : a - AW'(1);
	endfunction

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rdata_q;

	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] left_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic          pend_q;
	logic          drop_q;
	logic          strobe_q;
	logic          last_q;
	logic          empty_q;
	logic          drop_out_q;

	op_t               op;
	logic              is_ins;
	logic              full;
	logic              del_ok;
	logic [CW-1:0]     pos_c;
	logic [CW-1:0]     moves;
	logic [SW-1:0]     del_sum;
	logic [AW-1:0]     del_wr;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;

	// Decode of the incoming word.
	always_comb begin
		op      = op_t'(operation);
		is_ins  = op inside {OP_INS_FRONT, OP_APPEND};
		full    = (count_q == FULL_COUNT);
		del_ok  = (op == OP_DELETE) && (CMPW'(position) < CMPW'(count_q));
		pos_c   = CW'(position);
		moves   = count_q - pos_c - CW'(1);
		del_sum = SW'(head_q) + SW'(position);
		del_wr  = (del_sum >= CAP_SUM) ? AW'(del_sum - CAP_SUM) : AW'(del_sum);
	end

	// Status for the controller.
	always_comb begin
		sts.del_shift = del_ok && (moves != '0);
		sts.left_zero = (left_q == '0);
		sts.left_one  = (left_q == CW'(1));
		sts.empty     = (count_q == '0);
	end

	// Memory port selection: an insert on accept, or the lagging write of a shift.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_ptr_q;
		mem_wdata = rdata_q;
		if (cmd.accept && is_ins && !full) begin
			mem_we    = 1'b1;
			mem_waddr = (op == OP_INS_FRONT) ? addr_dec(head_q) : tail_q;
			mem_wdata = value;
		end else if (cmd.shift && pend_q) begin
			mem_we = 1'b1;
		end
		mem_re = (cmd.shift && (left_q != '0)) || cmd.report;
	end

	// Entry memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[rd_ptr_q];
		end
	end

	// List bookkeeping, shift and scan counters, result flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			left_q     <= '0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			pend_q     <= 1'b0;
			drop_q     <= 1'b0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
			empty_q    <= 1'b0;
			drop_out_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cmd.accept) begin
				drop_q <= is_ins && full;
				pend_q <= 1'b0;
				if (is_ins && !full) begin
					count_q <= count_q + CW'(1);
					if (op == OP_INS_FRONT) begin
						head_q <= addr_dec(head_q);
					end else begin
						tail_q <= addr_inc(tail_q);
					end
				end
				if (del_ok) begin
					count_q  <= count_q - CW'(1);
					tail_q   <= addr_dec(tail_q);
					wr_ptr_q <= del_wr;
					rd_ptr_q <= addr_inc(del_wr);
					left_q   <= moves;
				end
			end
			// Close the gap: read one entry ahead, write it one place down.
			if (cmd.shift) begin
				if (pend_q) begin
					wr_ptr_q <= addr_inc(wr_ptr_q);
				end
				if (left_q != '0) begin
					rd_ptr_q <= addr_inc(rd_ptr_q);
					left_q   <= left_q - CW'(1);
					pend_q   <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
			end
			// Set up the scan; an empty list gives its single result here.
			if (cmd.load) begin
				rd_ptr_q <= head_q;
				left_q   <= count_q;
				if (count_q == '0) begin
					strobe_q   <= 1'b1;
					last_q     <= 1'b1;
					empty_q    <= 1'b1;
					drop_out_q <= drop_q;
				end
			end
			// Scan front to back, one entry each cycle.
			if (cmd.report) begin
				rd_ptr_q   <= addr_inc(rd_ptr_q);
				left_q     <= left_q - CW'(1);
				strobe_q   <= 1'b1;
				last_q     <= (left_q == CW'(1));
				empty_q    <= 1'b0;
				drop_out_q <= drop_q;
			end
		end
	end

	assign result_valid = strobe_q;
	assign element      = empty_q ? '0 : rdata_q;
	assign is_last      = last_q;
	assign list_empty   = empty_q;
	assign dropped      = drop_out_q;

	`BLI_ASSERT_MSG(a_empty_single, clk, arst_n,
		strobe_q && empty_q |-> last_q && (count_q == '0), "empty result out of place")
	`BLI_ASSERT(a_insert_grows, clk, arst_n,
		cmd.accept && is_ins && !full |=> count_q == $past(count_q) + CW'(1))
	`BLI_ASSERT_MSG(a_last_ends_scan, clk, arst_n,
		strobe_q && last_q && !empty_q |-> left_q == '0, "last word before scan end")

endmodule

// ===== src/bounded_list_insert_delete.sv =====
// Top level of the bounded list block: controller plus datapath.
// Depends on bli_pkg, bli_ctrl and bli_dp.
//
//  Channel   Handshake              Ports
//  command   start & !busy          operation, value, position
//  result    result_valid strobe    element, is_last, list_empty, dropped
//
// An item is accepted; when a delete has to close a gap in the list, the entries
// behind it are shifted down; then the scan is set up and each entry held is read.
// Results appear in the cycle after their memory reads; the last one is shown in
// the cycle busy falls, so the next word can be taken at once.
// Reset clears the list to empty; entry memory contents are not cleared.
// The result side cannot stall: each word is on the ports for one cycle only.
module bounded_list_insert_delete import bli_pkg::*; #(
	parameter int CAPACITY = BLI_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [OP_W-1:0]          operation,
	input  logic signed [DATA_W-1:0] value,
	input  logic [POS_W-1:0]         position,
	output logic                     result_valid,
	output logic signed [DATA_W-1:0] element,
	output logic                     is_last,
	output logic                     list_empty,
	output logic                     dropped
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	bli_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// List storage and result path.
	bli_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.value        (value),
		.position     (position),
		.result_valid (result_valid),
		.element      (element),
		.is_last      (is_last),
		.list_empty   (list_empty),
		.dropped      (dropped)
	);

endmodule
